/* design/sliding_window_min_max_median_mean_unit_assert.svh */
// Assertion helpers for the sliding window statistics unit.
// Both expect i_clk and i_rst_n in the scope of use.
`ifndef SLIDING_WINDOW_MIN_MAX_MEDIAN_MEAN_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MIN_MAX_MEDIAN_MEAN_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SWMM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SWMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/swmm_pkg.sv */
package swmm_pkg;

    localparam int MAX_WINDOW  = 7;
    localparam int SAMPLE_BITS = 16;
    localparam int HALF_BITS   = 2;
    localparam int HALF_MAX    = (1 << HALF_BITS) - 1;
    localparam int LANES       = 2 * HALF_MAX + 1;
    localparam int CENTER      = HALF_MAX;
    localparam int LANE_BITS   = $clog2(LANES);
    localparam int DIST_BITS   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    localparam int FRAC_BITS   = 8;
    localparam int MEAN_BITS   = 24;
    localparam int SUM_BITS    = SAMPLE_BITS + LANE_BITS;
    localparam int MAG_BITS    = SUM_BITS - 1;
    // quotient = (|sum| * recip) >> DIV_SHIFT, recip = ceil(2^RECIP_SHIFT / n)
    localparam int DIV_SHIFT   = MAG_BITS + LANE_BITS;
    localparam int RECIP_SHIFT = DIV_SHIFT + FRAC_BITS;
    localparam int RECIP_BITS  = RECIP_SHIFT + 1;
    localparam int PROD_BITS   = MAG_BITS + RECIP_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic        [HALF_BITS-1:0]   t_half;
    typedef logic signed [SUM_BITS-1:0]    t_sum;
    typedef logic signed [MEAN_BITS-1:0]   t_mean;
    typedef logic        [LANE_BITS-1:0]   t_lane_idx;
    typedef logic        [RECIP_BITS-1:0]  t_recip;
    typedef t_sample     [LANES-1:0]       t_lanes;

    typedef struct packed {
        t_lanes lanes;
        t_sum   sum;
        logic   final_res;
    } t_win;

    localparam t_half   HALF_RESET = t_half'(1);
    localparam t_sample SAMPLE_HI  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample SAMPLE_LO  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_SHIFT;

    // Indexed by h; window length 2h+1.
    localparam t_recip RECIP_TABLE [HALF_MAX+1] = '{
        t_recip'(RECIP_ONE),
        t_recip'((RECIP_ONE + 64'd2) / 64'd3),
        t_recip'((RECIP_ONE + 64'd4) / 64'd5),
        t_recip'((RECIP_ONE + 64'd6) / 64'd7)
    };

endpackage

/* design/swmm_if.sv */
interface swmm_in_if;
    import swmm_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample;
    logic    last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

interface swmm_res_if;
    import swmm_pkg::*;
    logic    valid;
    logic    ready;
    t_sample window_max;
    t_sample window_min;
    t_sample window_median;
    t_mean   window_mean;
    logic    final_res;

    modport source (output valid, output window_max, output window_min,
                    output window_median, output window_mean, output final_res,
                    input ready);
    modport sink (input valid, input window_max, input window_min,
                  input window_median, input window_mean, input final_res,
                  output ready);
endinterface

interface swmm_cfg_if;
    import swmm_pkg::*;
    logic  valid;
    logic  ready;
    t_half window_half;

    modport source (output valid, output window_half, input ready);
    modport sink (input valid, input window_half, output ready);
endinterface

/* design/swmm_front.sv */
module swmm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  swmm_pkg::t_half i_half,
    swmm_in_if.sink        i_in,
    output swmm_pkg::t_win o_win,
    output logic           o_win_valid,
    input  logic           i_win_ready
);
    import swmm_pkg::*;

    t_sample r_line [MAX_WINDOW];
    t_half   r_seen;
    logic    r_flushing;
    t_half   r_flush_k;
    t_win    r_win;
    logic    r_win_valid;

    t_sample shifted [MAX_WINDOW];
    t_sample src [MAX_WINDOW];
    t_half   seen_eff;
    t_half   k_sel;
    logic    fin_sel;
    logic    win_free;
    logic    accept;
    logic    issue_in;
    logic    issue_fl;
    t_win    n_win;

    assign seen_eff    = (r_seen > i_half) ? i_half : r_seen;
    assign win_free    = !r_win_valid || i_win_ready;
    assign i_in.ready  = win_free && !r_flushing;
    assign accept      = i_in.valid && i_in.ready;
    assign issue_in    = accept && (i_in.last || (seen_eff >= i_half));
    assign issue_fl    = r_flushing && win_free;

    always_comb begin
        shifted[0] = i_in.sample;
        for (int a = 1; a < MAX_WINDOW; a++) begin
            shifted[a] = r_line[a-1];
        end
        for (int a = 0; a < MAX_WINDOW; a++) begin
            src[a] = r_flushing ? r_line[a] : shifted[a];
        end
    end

    assign k_sel   = r_flushing ? r_flush_k : (i_in.last ? seen_eff : i_half);
    assign fin_sel = r_flushing ? (r_flush_k == '0) : (i_in.last && (seen_eff == '0));

    // Lanes outside the window get paired low/high fillers so the sorted
    // middle lane stays the median.
    always_comb begin
        t_sample v;
        int      d;
        int      tap_pos;
        n_win.sum       = '0;
        n_win.final_res = fin_sel;
        for (int j = 0; j < LANES; j++) begin
            d       = j - CENTER;
            tap_pos = int'(k_sel) + d;
            if (d < -int'(i_half)) begin
                v = SAMPLE_LO;
            end else if (d > int'(i_half)) begin
                v = SAMPLE_HI;
            end else begin
                if ((tap_pos >= 0) && (tap_pos < MAX_WINDOW)) begin
                    v = src[DIST_BITS'(tap_pos)];
                end else begin
                    v = '0;
                end
                n_win.sum = n_win.sum + t_sum'(v);
            end
            n_win.lanes[j] = v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < MAX_WINDOW; a++) begin
                r_line[a] <= '0;
            end
            r_seen      <= '0;
            r_flushing  <= 1'b0;
            r_flush_k   <= '0;
            r_win_valid <= 1'b0;
        end else begin
            if (win_free) begin
                r_win_valid <= issue_in || issue_fl;
            end
            if (accept) begin
                if (i_in.last) begin
                    r_seen <= '0;
                    if (seen_eff == '0) begin
                        for (int a = 0; a < MAX_WINDOW; a++) begin
                            r_line[a] <= '0;
                        end
                    end else begin
                        for (int a = 0; a < MAX_WINDOW; a++) begin
                            r_line[a] <= shifted[a];
                        end
                        r_flushing <= 1'b1;
                        r_flush_k  <= seen_eff - 1'b1;
                    end
                end else begin
                    for (int a = 0; a < MAX_WINDOW; a++) begin
                        r_line[a] <= shifted[a];
                    end
                    if (seen_eff < i_half) begin
                        r_seen <= seen_eff + 1'b1;
                    end else begin
                        r_seen <= seen_eff;
                    end
                end
            end
            if (issue_fl) begin
                if (r_flush_k == '0) begin
                    r_flushing <= 1'b0;
                    for (int a = 0; a < MAX_WINDOW; a++) begin
                        r_line[a] <= '0;
                    end
                end else begin
                    r_flush_k <= r_flush_k - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue_in || issue_fl) begin
            r_win <= n_win;
        end
    end

    assign o_win       = r_win;
    assign o_win_valid = r_win_valid;

endmodule

/* design/swmm_sort.sv */
module swmm_sort (
    input  swmm_pkg::t_lanes i_lanes,
    output swmm_pkg::t_lanes o_sorted
);
    import swmm_pkg::*;

    // Odd-even transposition network: LANES rounds of compare-exchange.
    always_comb begin
        t_lanes  v;
        t_sample a;
        t_sample b;
        v = i_lanes;
        for (int r = 0; r < LANES; r++) begin
            for (int j = (r & 1); j + 1 < LANES; j += 2) begin
                a = v[j];
                b = v[j+1];
                if (a > b) begin
                    v[j]   = b;
                    v[j+1] = a;
                end
            end
        end
        o_sorted = v;
    end

endmodule

/* design/swmm_mean.sv */
module swmm_mean (
    input  swmm_pkg::t_sum  i_sum,
    input  swmm_pkg::t_half i_half,
    output swmm_pkg::t_mean o_mean
);
    import swmm_pkg::*;

    logic                 neg;
    logic [MAG_BITS-1:0]  mag;
    logic [PROD_BITS-1:0] prod;
    logic [MEAN_BITS:0]   quo;

    // Divide the magnitude so the result truncates toward zero.
    assign neg  = i_sum[SUM_BITS-1];
    assign mag  = neg ? MAG_BITS'(-i_sum) : MAG_BITS'(i_sum);
    assign prod = PROD_BITS'(mag) * PROD_BITS'(RECIP_TABLE[i_half]);
    assign quo  = prod[DIV_SHIFT +: MEAN_BITS+1];

    assign o_mean = neg ? MEAN_BITS'(-quo) : MEAN_BITS'(quo);

endmodule

/* design/sliding_window_min_max_median_mean_unit.sv */
// Sliding window statistics unit. For each sample of a stream it returns the
// maximum, minimum, median and mean (8 fraction bits, truncated toward zero)
// of the 2h+1 samples centred on it, with zeros standing in for positions
// before the start and after the end of the stream. h comes from the
// configuration channel (reset 1); write it only while the unit is idle.
// Results lag the samples by h positions: the first h samples of a stream
// produce no result, and the sample flagged last releases the pending ones,
// the final result carrying final_res. The unit takes one sample per clock
// while the result path does not stall; a last sample with p pending
// positions (at most h) holds off the input while its flush windows issue
// from the delay line. Each window is captured in the window register, then
// passes the sorting network and the reciprocal multiply for the mean into
// the result register. No clearing pass after reset.
module sliding_window_min_max_median_mean_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    swmm_cfg_if.sink  i_cfg,
    swmm_in_if.sink   i_in,
    swmm_res_if.source o_res
);
    import swmm_pkg::*;

    t_half     r_window_half;
    t_win      win;
    logic      win_valid;
    logic      win_ready;
    t_lanes    sorted;
    t_mean     mean;
    t_lane_idx lo_idx;
    t_lane_idx hi_idx;

    logic      r_out_valid;
    t_sample   r_max;
    t_sample   r_min;
    t_sample   r_median;
    t_mean     r_mean;
    logic      r_final;

    // Configuration: accept every transfer, hold h until the next write.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_half <= HALF_RESET;
        end else if (i_cfg.valid) begin
            r_window_half <= i_cfg.window_half;
        end
    end

    // Delay line, flush sequencing and window register.
    swmm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_half      (r_window_half),
        .i_in        (i_in),
        .o_win       (win),
        .o_win_valid (win_valid),
        .i_win_ready (win_ready)
    );

    swmm_sort u_sort (
        .i_lanes  (win.lanes),
        .o_sorted (sorted)
    );

    swmm_mean u_mean (
        .i_sum  (win.sum),
        .i_half (r_window_half),
        .o_mean (mean)
    );

    // Fillers occupy the outer CENTER-h lanes at each end of the sorted
    // order, so min and max sit h lanes either side of the median.
    assign lo_idx = t_lane_idx'(CENTER) - t_lane_idx'(r_window_half);
    assign hi_idx = t_lane_idx'(CENTER) + t_lane_idx'(r_window_half);

    // Result register: advance when empty or when the sink takes the result.
    assign win_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (win_ready) begin
            r_out_valid <= win_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (win_ready && win_valid) begin
            r_max    <= sorted[hi_idx];
            r_min    <= sorted[lo_idx];
            r_median <= sorted[CENTER];
            r_mean   <= mean;
            r_final  <= win.final_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.window_max    = r_max;
    assign o_res.window_min    = r_min;
    assign o_res.window_median = r_median;
    assign o_res.window_mean   = r_mean;
    assign o_res.final_res     = r_final;

`include "sliding_window_min_max_median_mean_unit_assert.svh"

    `SWMM_ASSERT_NOW(a_stats_order, r_out_valid, (r_min <= r_median) && (r_median <= r_max), "window statistics out of order")
    `SWMM_ASSERT_NOW(a_stall_blocks_input, win_valid && !win_ready, !i_in.ready, "input taken while both stages are full")
    `SWMM_ASSERT_NEXT(a_window_holds, win_valid && !win_ready, win_valid && $stable(win), "stalled window changed or dropped")

endmodule

/* verif/window_stats_checker.sv */
module window_stats_checker
    import swmm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    swmm_cfg_if  i_cfg,
    swmm_in_if   i_in,
    swmm_res_if  i_res,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_sample wmax;
        t_sample wmin;
        t_sample wmed;
        t_mean   wmean;
        logic    fin;
    } win_stats_t;

    t_half      half_q;
    t_sample    taps [MAX_WINDOW];
    int         seen_q;
    win_stats_t stats_due [$];

    // Statistics of the window centred `centre` samples behind the newest tap.
    function automatic win_stats_t window_stats(int centre, int half, logic fin);
        int         vals [LANES];
        int         n, i, j, tmp, hi, lo;
        longint     total;
        win_stats_t r;
        n     = 2 * half + 1;
        total = 0;
        for (i = 0; i < n; i++) begin
            j = centre + half - i;
            vals[i] = (j >= 0 && j < MAX_WINDOW) ? int'(taps[j]) : 0;
        end
        hi = vals[0];
        lo = vals[0];
        for (i = 0; i < n; i++) begin
            if (vals[i] > hi) hi = vals[i];
            if (vals[i] < lo) lo = vals[i];
            total += vals[i];
        end
        for (i = 0; i < n - 1; i++) begin
            for (j = 0; j < n - 1 - i; j++) begin
                if (vals[j] > vals[j+1]) begin
                    tmp       = vals[j];
                    vals[j]   = vals[j+1];
                    vals[j+1] = tmp;
                end
            end
        end
        r.wmax  = t_sample'(hi);
        r.wmin  = t_sample'(lo);
        r.wmed  = t_sample'(vals[half]);
        // signed division truncates toward zero
        r.wmean = t_mean'((total * 256) / longint'(n));
        r.fin   = fin;
        return r;
    endfunction

    function automatic void take_sample(t_sample value, logic is_last);
        int h, seen, i, k;
        h    = int'(half_q);
        seen = (seen_q > h) ? h : seen_q;
        for (i = MAX_WINDOW - 1; i > 0; i--) taps[i] = taps[i-1];
        taps[0] = value;
        if (!is_last) begin
            if (seen >= h) stats_due.push_back(window_stats(h, h, 1'b0));
            if (seen < h) seen++;
            seen_q = seen;
        end else begin
            // flush the pending positions oldest first, then start clean
            for (k = seen; k >= 0; k--) stats_due.push_back(window_stats(k, h, k == 0));
            foreach (taps[i]) taps[i] = '0;
            seen_q = 0;
        end
    endfunction

    function automatic void check_result();
        win_stats_t want, got;
        got = '{wmax: i_res.window_max, wmin: i_res.window_min,
                wmed: i_res.window_median, wmean: i_res.window_mean,
                fin: i_res.final_res};
        if (stats_due.size() == 0) begin
            o_errors++;
            if (o_errors <= REPORT_LIMIT)
                $display("unexpected result at %0t: max %0d min %0d median %0d mean %0d final %0b",
                         $time, got.wmax, got.wmin, got.wmed, got.wmean, got.fin);
        end else begin
            want = stats_due.pop_front();
            o_checked++;
            if (got !== want) begin
                o_errors++;
                if (o_errors <= REPORT_LIMIT) begin
                    $display("mismatch at %0t, result %0d:", $time, o_checked);
                    $display("  expected max %0d min %0d median %0d mean %0d final %0b",
                             want.wmax, want.wmin, want.wmed, want.wmean, want.fin);
                    $display("  actual   max %0d min %0d median %0d mean %0d final %0b",
                             got.wmax, got.wmin, got.wmed, got.wmean, got.fin);
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            half_q = HALF_RESET;
            foreach (taps[i]) taps[i] = '0;
            seen_q = 0;
            stats_due.delete();
            o_errors  = 0;
            o_checked = 0;
        end else begin
            if (i_res.valid && i_res.ready) check_result();
            if (i_cfg.valid && i_cfg.ready) half_q = i_cfg.window_half;
            if (i_in.valid && i_in.ready) take_sample(i_in.sample, i_in.last);
        end
        o_pending = stats_due.size();
    end

endmodule

/* verif/tb.sv */
module tb;
    import swmm_pkg::*;

    localparam int RANDOM_ITEMS   = 240;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 1000;

    logic clk = 1'b0;
    logic rst_n;

    swmm_cfg_if cfg_ch ();
    swmm_in_if  in_ch ();
    swmm_res_if res_ch ();

    int errors, pending, checked;
    int samples_sent, streams_sent, mid_changes, quiet_cycles;
    bit src_steady, sink_steady;
    bit [HALF_MAX:0] halves_used;

    sliding_window_min_max_median_mean_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    window_stats_checker u_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg     (cfg_ch),
        .i_in      (in_ch),
        .i_res     (res_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked)
    );

    always #6 clk = ~clk;

    // Bail out if nothing moves on any channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int draw_wait(bit steady);
        return steady ? 0 : int'($urandom_range(0, 17));
    endfunction

    function automatic t_sample rand_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_HI;
            1:       return SAMPLE_LO;
            2:       return '0;
            3, 4:    return t_sample'(int'($urandom_range(0, 16)) - 8);
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic send_sample(input t_sample value, input logic is_last);
        int gap;
        gap = draw_wait(src_steady);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= value;
        in_ch.last   <= is_last;
        do @(posedge clk); while (!in_ch.ready);
        samples_sent++;
        if (is_last) streams_sent++;
    endtask

    // Drop valid, drain every expected result, then let the pipe settle.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_half(input t_half value);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.window_half <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        halves_used[value] = 1'b1;
    endtask

    task automatic send_stream();
        int len, i;
        len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(11, 24))
                                          : int'($urandom_range(1, 10));
        for (i = 0; i < len; i++) begin
            // occasionally switch the window between two samples of one stream
            if (i > 0 && $urandom_range(0, 11) == 0) begin
                wait_idle();
                write_half(t_half'($urandom_range(0, HALF_MAX)));
                mid_changes++;
            end
            send_sample(rand_sample(), i == len - 1);
        end
    endtask

    initial begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = draw_wait(sink_steady);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    initial begin : stimulus
        int phase, target;
        rst_n              <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.sample       <= '0;
        in_ch.last         <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.window_half <= HALF_RESET;
        res_ch.ready       <= 1'b0;
        halves_used[HALF_RESET] = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window h=1 with both sample extremes
        send_sample(SAMPLE_HI, 1'b0);
        send_sample(SAMPLE_LO, 1'b0);
        send_sample('0, 1'b1);

        // h=0: every sample is its own window
        wait_idle();
        write_half(t_half'(0));
        send_sample(SAMPLE_LO, 1'b0);
        send_sample(SAMPLE_HI, 1'b1);

        // h=3: streams shorter than h, then full windows at the extremes
        wait_idle();
        write_half(t_half'(HALF_MAX));
        send_sample(t_sample'(100), 1'b0);
        send_sample(t_sample'(-200), 1'b1);
        send_sample(SAMPLE_HI, 1'b1);
        repeat (6) send_sample(SAMPLE_LO, 1'b0);
        send_sample(SAMPLE_LO, 1'b1);
        repeat (6) send_sample(SAMPLE_HI, 1'b0);
        send_sample(SAMPLE_HI, 1'b1);

        // shrink the window mid-stream below the samples already seen
        wait_idle();
        write_half(t_half'(2));
        send_sample(t_sample'(7), 1'b0);
        send_sample(t_sample'(-9), 1'b0);
        send_sample(t_sample'(300), 1'b0);
        wait_idle();
        write_half(t_half'(1));
        mid_changes++;
        send_sample(t_sample'(-1), 1'b0);
        send_sample(t_sample'(42), 1'b1);

        // random streams, cycling through extreme and random window sizes
        target = samples_sent + RANDOM_ITEMS;
        phase  = 0;
        while (samples_sent < target) begin
            wait_idle();
            case (phase % 4)
                0:       write_half(t_half'(0));
                1:       write_half(t_half'(HALF_MAX));
                default: write_half(t_half'($urandom_range(0, HALF_MAX)));
            endcase
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3)) send_stream();
            phase++;
        end

        wait_idle();
        repeat (8) @(posedge clk);

        $display("ran %0d samples in %0d streams, %0d window results checked",
                 samples_sent, streams_sent, checked);
        $display("half-window values used (bit h): %b, window changes mid-stream: %0d",
                 halves_used, mid_changes);
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
